[rtl/core/bnig_pkg.sv]
`default_nettype none
package bnig_pkg;

  localparam int IDX_W    = 20;  // linear index width
  localparam int CRD_W    = 10;  // signed walk coordinate: -3 .. 258
  localparam int DVD_W    = 10;  // centre - radius + 3*size, 0 .. 1023
  localparam int STEP_W   = 4;   // counts DVD_W remainder steps
  localparam int GRID_MAX = 256; // size fields saturate here; widths above assume it

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_START,
    ST_MOD_WAIT,
    ST_MUL_YZ,
    ST_MUL_X,
    ST_MUL_Y,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // walker -> emit stage
  typedef struct packed {
    logic             take;   // walker steps this cycle
    logic             hit;    // current cell gives an index
    logic [IDX_W-1:0] idx;
    logic             flush;  // walk over, release held item
  } emit_req_t;

  // emit stage -> walker
  typedef struct packed {
    logic ready;    // a step may be taken now
    logic full;     // limit passed, more indices existed
    logic flushed;  // held item gone, query finished
  } emit_rsp_t;

endpackage
`default_nettype wire

[rtl/core/box_neighbourhood_index_generator.sv]
`default_nettype none
// Channel | Signals                                   | Direction
// query   | in_valid, in_stall, centre/radius/size,   | in, stall out
//         | base_index, self_index                    |
// result  | out_valid, out_stall, neighbor_index,     | out, stall in
//         | last, truncated                           |
// config  | cfg_we, cfg_wdata (wrap_mode)             | in, no wait
//
// One query at a time: in_stall is high from acceptance until the query's final
// item is in the output register. The walk visits V = (2rx+1)(2ry+1)(2rz+1) cells;
// torus mode first reduces each axis start in the shared remainder unit. A walk
// cut at the result limit ends early, and output stalls can hold the walk.
// A zero size ends the query at once with no items. rst (synchronous) clears the
// sequencer, wrap_mode and the output valid.
module box_neighbourhood_index_generator #(
  parameter int MAX_RESULTS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  // query
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  center_x,
  input  wire logic [7:0]  center_y,
  input  wire logic [7:0]  center_z,
  input  wire logic [1:0]  radius_x,
  input  wire logic [1:0]  radius_y,
  input  wire logic [1:0]  radius_z,
  input  wire logic [8:0]  size_x,
  input  wire logic [8:0]  size_y,
  input  wire logic [8:0]  size_z,
  input  wire logic [19:0] base_index,
  input  wire logic [19:0] self_index,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [19:0]      neighbor_index,
  output logic             last,
  output logic             truncated
);

  localparam int IW = bnig_pkg::IDX_W;
  localparam int CW = bnig_pkg::CRD_W;

  bnig_pkg::state_t state, state_next;

  logic             wrap_mode;
  logic [1:0]       ax;                 // axis under remainder reduction

  // query registers, one entry per axis (x, y, z)
  logic [7:0]       ctr [3];
  logic [1:0]       rad [3];
  logic [8:0]       siz [3];            // already saturated to GRID_MAX
  logic [IW-1:0]    base;
  logic [IW-1:0]    self_idx;

  // walk start coordinates, signed in clip mode
  logic signed [CW-1:0] st [3];
  logic [16:0]      syz;                // size_y * size_z, up to 65536
  logic [IW-1:0]    oy0;

  // walk position
  logic signed [CW-1:0] cx, cy, cz;
  logic [IW-1:0]    ox, oy;
  logic [2:0]       dx, dy, dz;

  // shared multiplier
  logic [16:0]          mul_a;
  logic signed [CW-1:0] mul_b;
  logic signed [27:0]   mul_p;

  // remainder unit
  logic                        mod_start;
  logic                        mod_done;
  logic [7:0]                  mod_rem;
  logic [bnig_pkg::DVD_W-1:0]  mod_dvd;

  logic                  any_zero;
  logic                  accept;
  logic                  x_ok, y_ok, z_ok, cell_ok;
  logic [IW-1:0]         idx;
  logic                  x_end, y_end, z_end;
  logic                  xw, yw, zw;
  logic                  step;
  bnig_pkg::emit_req_t   ereq;
  bnig_pkg::emit_rsp_t   ersp;

  function automatic logic [8:0] sat_size(input logic [8:0] s);
    if ({4'b0, s} > 13'(bnig_pkg::GRID_MAX)) begin
      return 9'(bnig_pkg::GRID_MAX);
    end
    return s;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_mode <= 1'b0;
    end else if (cfg_we) begin
      wrap_mode <= cfg_wdata;
    end
  end

  assign any_zero = (size_x == '0) || (size_y == '0) || (size_z == '0);
  assign in_stall = (state != bnig_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // torus start: (c - r + 3s) mod s, the 3s keeps the dividend non-negative
  assign mod_dvd = 10'(ctr[ax]) - 10'(rad[ax]) + 10'(siz[ax]) + {siz[ax], 1'b0};
  assign mod_start = (state == bnig_pkg::ST_MOD_START);

  bnig_modunit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (siz[ax]),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // multiplier operands by phase; only the low index bits are kept
  always_comb begin
    case (state)
      bnig_pkg::ST_MUL_X: begin
        mul_a = syz;
        mul_b = st[0];
      end
      bnig_pkg::ST_MUL_Y: begin
        mul_a = 17'(siz[2]);
        mul_b = st[1];
      end
      default: begin
        mul_a = 17'(siz[1]);
        mul_b = $signed({1'b0, siz[2]});
      end
    endcase
  end

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // cell test and index for the current walk position
  assign x_ok    = !cx[CW-1] && (cx[8:0] < siz[0]);
  assign y_ok    = !cy[CW-1] && (cy[8:0] < siz[1]);
  assign z_ok    = !cz[CW-1] && (cz[8:0] < siz[2]);
  assign cell_ok = wrap_mode || (x_ok && y_ok && z_ok);
  assign idx     = base + ox + oy + IW'(cz[8:0]);

  assign z_end = (dz == {rad[2], 1'b0});
  assign y_end = (dy == {rad[1], 1'b0});
  assign x_end = (dx == {rad[0], 1'b0});

  // torus wrap back to zero at the top of the axis
  assign xw = wrap_mode && (cx[8:0] == siz[0] - 9'd1);
  assign yw = wrap_mode && (cy[8:0] == siz[1] - 9'd1);
  assign zw = wrap_mode && (cz[8:0] == siz[2] - 9'd1);

  assign step = (state == bnig_pkg::ST_WALK) && ersp.ready;

  assign ereq.take  = step;
  assign ereq.hit   = cell_ok && (idx != self_idx);
  assign ereq.idx   = idx;
  assign ereq.flush = (state == bnig_pkg::ST_FLUSH);

  bnig_emit #(
    .MAX_RESULTS (MAX_RESULTS)
  ) u_emit (
    .clk            (clk),
    .rst            (rst),
    .req            (ereq),
    .rsp            (ersp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .neighbor_index (neighbor_index),
    .last           (last),
    .truncated      (truncated)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bnig_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      bnig_pkg::ST_IDLE: begin
        if (accept) begin
          if (any_zero) begin
            state_next = bnig_pkg::ST_IDLE;
          end else if (wrap_mode) begin
            state_next = bnig_pkg::ST_MOD_START;
          end else begin
            state_next = bnig_pkg::ST_MUL_YZ;
          end
        end
      end
      bnig_pkg::ST_MOD_START: begin
        state_next = bnig_pkg::ST_MOD_WAIT;
      end
      bnig_pkg::ST_MOD_WAIT: begin
        if (mod_done) begin
          state_next = (ax == 2'd2) ? bnig_pkg::ST_MUL_YZ : bnig_pkg::ST_MOD_START;
        end
      end
      bnig_pkg::ST_MUL_YZ: begin
        state_next = bnig_pkg::ST_MUL_X;
      end
      bnig_pkg::ST_MUL_X: begin
        state_next = bnig_pkg::ST_MUL_Y;
      end
      bnig_pkg::ST_MUL_Y: begin
        state_next = bnig_pkg::ST_WALK;
      end
      bnig_pkg::ST_WALK: begin
        if (ersp.full) begin
          state_next = bnig_pkg::ST_FLUSH;
        end else if (step && x_end && y_end && z_end) begin
          state_next = bnig_pkg::ST_FLUSH;
        end
      end
      bnig_pkg::ST_FLUSH: begin
        if (ersp.flushed) begin
          state_next = bnig_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bnig_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ax <= '0;
    end else if (accept) begin
      ax <= '0;
    end else if (state == bnig_pkg::ST_MOD_WAIT && mod_done) begin
      ax <= ax + 2'd1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      bnig_pkg::ST_IDLE: begin
        if (accept) begin
          ctr[0]   <= center_x;
          ctr[1]   <= center_y;
          ctr[2]   <= center_z;
          rad[0]   <= radius_x;
          rad[1]   <= radius_y;
          rad[2]   <= radius_z;
          siz[0]   <= sat_size(size_x);
          siz[1]   <= sat_size(size_y);
          siz[2]   <= sat_size(size_z);
          base     <= base_index;
          self_idx <= self_index;
          // clip mode walks straight from centre minus radius
          st[0]    <= $signed(10'(center_x) - 10'(radius_x));
          st[1]    <= $signed(10'(center_y) - 10'(radius_y));
          st[2]    <= $signed(10'(center_z) - 10'(radius_z));
        end
      end
      bnig_pkg::ST_MOD_WAIT: begin
        if (mod_done) begin
          st[ax] <= $signed({2'b00, mod_rem});
        end
      end
      bnig_pkg::ST_MUL_YZ: begin
        syz <= mul_p[16:0];
      end
      bnig_pkg::ST_MUL_X: begin
        ox <= mul_p[IW-1:0];
        cx <= st[0];
        dx <= '0;
      end
      bnig_pkg::ST_MUL_Y: begin
        oy0 <= mul_p[IW-1:0];
        oy  <= mul_p[IW-1:0];
        cy  <= st[1];
        dy  <= '0;
        cz  <= st[2];
        dz  <= '0;
      end
      bnig_pkg::ST_WALK: begin
        if (step && !ersp.full) begin
          if (!z_end) begin
            dz <= dz + 3'd1;
            cz <= zw ? '0 : cz + 10'sd1;
          end else begin
            dz <= '0;
            cz <= st[2];
            if (!y_end) begin
              dy <= dy + 3'd1;
              cy <= yw ? '0 : cy + 10'sd1;
              oy <= yw ? '0 : oy + IW'(siz[2]);
            end else begin
              dy <= '0;
              cy <= st[1];
              oy <= oy0;
              dx <= dx + 3'd1;
              cx <= xw ? '0 : cx + 10'sd1;
              ox <= xw ? '0 : ox + IW'(syz);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/core/bnig_modunit.sv]
`default_nettype none
// Restoring remainder, one dividend bit per cycle.
module bnig_modunit (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [bnig_pkg::DVD_W-1:0] dividend,
  input  wire logic [8:0]                divisor,
  output logic                           done,
  output logic [7:0]                     rem
);

  logic                       busy;
  logic [bnig_pkg::DVD_W-1:0] dvd;
  logic [bnig_pkg::STEP_W-1:0] cnt;
  logic [8:0]                 trial;
  logic [7:0]                 rem_next;

  assign trial = {rem, dvd[bnig_pkg::DVD_W-1]};

  // partial remainder stays below divisor (<= 256), so 8 bits hold it
  always_comb begin
    if (trial >= divisor) begin
      rem_next = 8'(trial - divisor);
    end else begin
      rem_next = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == bnig_pkg::STEP_W'(bnig_pkg::DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      dvd <= {dvd[bnig_pkg::DVD_W-2:0], 1'b0};
      rem <= rem_next;
      cnt <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/bnig_emit.sv]
`default_nettype none
// Holds one index back so the final one can carry last/truncated,
// and drives the output register.
module bnig_emit #(
  parameter int MAX_RESULTS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire bnig_pkg::emit_req_t        req,
  output bnig_pkg::emit_rsp_t             rsp,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [bnig_pkg::IDX_W-1:0]      neighbor_index,
  output logic                            last,
  output logic                            truncated
);

  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  logic [CNT_W-1:0]           cnt;
  logic                       more;
  logic [bnig_pkg::IDX_W-1:0] pend;
  logic                       free;
  logic                       has;
  logic                       below;
  logic                       load_mid;
  logic                       load_fin;

  assign free  = !out_valid || !out_stall;
  assign has   = (cnt != '0);
  assign below = (cnt < CNT_W'(MAX_RESULTS));

  assign rsp.ready   = !(req.hit && has && below) || free;
  assign rsp.full    = more;
  assign rsp.flushed = !has || free;

  assign load_mid = req.take && req.hit && below && has;
  assign load_fin = req.flush && has && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      more      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_mid || load_fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (req.take && req.hit) begin
        if (below) begin
          cnt <= cnt + 1'b1;
        end else begin
          more <= 1'b1;
        end
      end
      if (req.flush && rsp.flushed) begin
        cnt  <= '0;
        more <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.take && req.hit && below) begin
      pend <= req.idx;
    end
    if (load_mid) begin
      neighbor_index <= pend;
      last           <= 1'b0;
      truncated      <= 1'b0;
    end else if (load_fin) begin
      neighbor_index <= pend;
      last           <= 1'b1;
      truncated      <= more;
    end
  end

endmodule
`default_nettype wire

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Index width comes from the block's package; the rest is local to the bench.
  localparam int IW       = bnig_pkg::IDX_W;
  localparam int LIMIT    = 64;    // most neighbours given out per query
  localparam int SIZE_CAP = 256;   // larger size fields saturate to this
  localparam int SETTLE   = 450;   // torus worst case of 343 cells, plus margin
  localparam int HOLD_OFF = 400;   // long receiver hold-off, in cycles

  typedef enum logic {
    WRAP_CLIP  = 1'b0,
    WRAP_TORUS = 1'b1
  } wrap_e;

  typedef struct {
    logic [7:0]    cx, cy, cz;
    logic [1:0]    rx, ry, rz;
    logic [8:0]    sx, sy, sz;
    logic [IW-1:0] base;
    logic [IW-1:0] self_idx;
  } query_t;

  typedef struct packed {
    logic [IW-1:0] idx;
    logic          last;
    logic          trunc;
  } nbr_t;

  // Works out the neighbour list of each accepted query and holds it until
  // the block hands the items back, oldest first.
  class neighbour_ledger;
    nbr_t  expected[$];
    wrap_e wrap = WRAP_CLIP;
    int    failures, queries, results, cut_queries, empty_queries;

    function int fold_axis(int v, int size, wrap_e mode);
      int m;
      if (size <= 0) return -1;
      if (mode == WRAP_TORUS) begin
        m = v % size;
        if (m < 0) m += size;
        return m;
      end
      if (v < 0 || v >= size) return -1;
      return v;
    endfunction

    function void note_query(query_t q);
      int c[3], r[3], s[3];
      int x, y, z;
      bit more;
      longint unsigned lin;
      logic [IW-1:0] idx;
      logic [IW-1:0] hits[$];
      nbr_t e;
      c[0] = int'(q.cx); c[1] = int'(q.cy); c[2] = int'(q.cz);
      r[0] = int'(q.rx); r[1] = int'(q.ry); r[2] = int'(q.rz);
      s[0] = (q.sx > SIZE_CAP) ? SIZE_CAP : int'(q.sx);
      s[1] = (q.sy > SIZE_CAP) ? SIZE_CAP : int'(q.sy);
      s[2] = (q.sz > SIZE_CAP) ? SIZE_CAP : int'(q.sz);
      more = 1'b0;
      for (int dx = -r[0]; dx <= r[0]; dx++) begin
        x = fold_axis(c[0] + dx, s[0], wrap);
        if (x < 0) continue;
        for (int dy = -r[1]; dy <= r[1]; dy++) begin
          y = fold_axis(c[1] + dy, s[1], wrap);
          if (y < 0) continue;
          for (int dz = -r[2]; dz <= r[2]; dz++) begin
            z = fold_axis(c[2] + dz, s[2], wrap);
            if (z < 0) continue;
            lin = longint'(q.base) + longint'(x) * s[1] * s[2] + longint'(y) * s[2] + z;
            idx = lin[IW-1:0];
            if (idx == q.self_idx) continue;
            if (hits.size() < LIMIT) hits.push_back(idx);
            else more = 1'b1;
          end
        end
      end
      foreach (hits[i]) begin
        e.idx   = hits[i];
        e.last  = (i == hits.size() - 1);
        e.trunc = e.last && more;
        expected.push_back(e);
      end
      queries++;
      if (hits.size() == 0) empty_queries++;
      if (more) cut_queries++;
    endfunction

    function void check_index(logic [IW-1:0] idx, logic lst, logic trc);
      nbr_t e;
      if (expected.size() == 0) begin
        failures++;
        $display("%0t: item with none expected: idx=%h last=%b truncated=%b",
                 $time, idx, lst, trc);
        return;
      end
      e = expected.pop_front();
      results++;
      if (idx !== e.idx) begin
        failures++;
        $display("%0t: neighbor_index expected %h actual %h", $time, e.idx, idx);
      end
      if (lst !== e.last) begin
        failures++;
        $display("%0t: last expected %b actual %b (idx %h)", $time, e.last, lst, e.idx);
      end
      if (trc !== e.trunc) begin
        failures++;
        $display("%0t: truncated expected %b actual %b (idx %h)", $time, e.trunc, trc, e.idx);
      end
    endfunction
  endclass

  neighbour_ledger ledger = new;

  // Every input starts at a known value.
  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          cfg_we    = 1'b0;
  logic          cfg_wdata = 1'b0;
  logic          in_valid  = 1'b0;
  logic          in_stall;
  logic [7:0]    center_x  = '0;
  logic [7:0]    center_y  = '0;
  logic [7:0]    center_z  = '0;
  logic [1:0]    radius_x  = '0;
  logic [1:0]    radius_y  = '0;
  logic [1:0]    radius_z  = '0;
  logic [8:0]    size_x    = '0;
  logic [8:0]    size_y    = '0;
  logic [8:0]    size_z    = '0;
  logic [IW-1:0] base_index = '0;
  logic [IW-1:0] self_index = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [IW-1:0] neighbor_index;
  logic          last;
  logic          truncated;

  bit calm        = 1'b0;  // final stretch: neither side idles
  bit hold_wanted = 1'b0;  // sender asks the receiver for one long hold-off
  int holds_done  = 0;
  int wrap_writes = 0;

  box_neighbourhood_index_generator DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .center_x       (center_x),
    .center_y       (center_y),
    .center_z       (center_z),
    .radius_x       (radius_x),
    .radius_y       (radius_y),
    .radius_z       (radius_z),
    .size_x         (size_x),
    .size_y         (size_y),
    .size_z         (size_z),
    .base_index     (base_index),
    .self_index     (self_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .neighbor_index (neighbor_index),
    .last           (last),
    .truncated      (truncated)
  );

  always #4 clk = ~clk;

  // Result side. Sampled at the edge, so outputs and out_stall are both the
  // values from before the edge.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      ledger.check_index(neighbor_index, last, truncated);
  end

  // Receiver: short random stall bursts, plus one long hold-off on request.
  // The hold-off is counted here so the sender can keep offering meanwhile;
  // with one query in flight the block then has to hold in_stall high.
  initial begin
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left   = HOLD_OFF;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(0, 4);   // random burst length
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one query and wait for it to be taken. in_valid is only lowered
  // for an idle gap, so back-to-back items keep it high throughout.
  task automatic offer_query(input query_t q);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    center_x   <= q.cx;
    center_y   <= q.cy;
    center_z   <= q.cz;
    radius_x   <= q.rx;
    radius_y   <= q.ry;
    radius_z   <= q.rz;
    size_x     <= q.sx;
    size_y     <= q.sy;
    size_z     <= q.sz;
    base_index <= q.base;
    self_index <= q.self_idx;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    ledger.note_query(q);
  endtask

  // Stop offering, let every expected item come back, then give the block
  // time to finish a query that yields nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ledger.expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_wrap(input wrap_e mode);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    ledger.wrap = mode;
    cfg_we <= 1'b0;
    wrap_writes++;
  endtask

  function automatic query_t box_query(int cx, int cy, int cz, int rx, int ry, int rz,
                                       int sx, int sy, int sz, int base, int self_idx);
    query_t q;
    q.cx = 8'(cx); q.cy = 8'(cy); q.cz = 8'(cz);
    q.rx = 2'(rx); q.ry = 2'(ry); q.rz = 2'(rz);
    q.sx = 9'(sx); q.sy = 9'(sy); q.sz = 9'(sz);
    q.base = IW'(base);
    q.self_idx = IW'(self_idx);
    return q;
  endfunction

  // Mostly small in-grid boxes; the rest oversized grids, centres off the
  // grid, empty axes and fully random fields.
  function automatic query_t random_query();
    query_t q;
    int kind, sy, sz;
    kind = $urandom_range(0, 99);
    q.rx = 2'($urandom_range(0, 3));
    q.ry = 2'($urandom_range(0, 3));
    q.rz = 2'($urandom_range(0, 3));
    q.base = IW'($urandom_range(0, (1 << IW) - 1));
    if (kind < 70) begin
      q.sx = 9'($urandom_range(1, 12));
      q.sy = 9'($urandom_range(1, 12));
      q.sz = 9'($urandom_range(1, 40));
      q.cx = 8'($urandom_range(0, q.sx - 1));
      q.cy = 8'($urandom_range(0, q.sy - 1));
      q.cz = 8'($urandom_range(0, q.sz - 1));
    end else if (kind < 80) begin
      q.sx = 9'($urandom_range(0, 511));
      q.sy = 9'($urandom_range(0, 511));
      q.sz = 9'($urandom_range(0, 511));
      q.cx = 8'($urandom_range(0, 255));
      q.cy = 8'($urandom_range(0, 255));
      q.cz = 8'($urandom_range(0, 255));
    end else if (kind < 90) begin
      q.sx = 9'($urandom_range(1, 8));
      q.sy = 9'($urandom_range(1, 8));
      q.sz = 9'($urandom_range(1, 8));
      q.cx = 8'($urandom_range(0, 255));
      q.cy = 8'($urandom_range(0, 255));
      q.cz = 8'($urandom_range(0, 255));
    end else begin
      q.sx = 9'($urandom_range(1, 16));
      q.sy = 9'($urandom_range(1, 16));
      q.sz = 9'($urandom_range(1, 16));
      case ($urandom_range(0, 2))
        0: q.sx = '0;
        1: q.sy = '0;
        default: q.sz = '0;
      endcase
      q.cx = 8'($urandom_range(0, 15));
      q.cy = 8'($urandom_range(0, 15));
      q.cz = 8'($urandom_range(0, 15));
    end
    // querying cell usually sits at or next to the centre
    sy = (q.sy > SIZE_CAP) ? SIZE_CAP : int'(q.sy);
    sz = (q.sz > SIZE_CAP) ? SIZE_CAP : int'(q.sz);
    if ($urandom_range(0, 3) != 0)
      q.self_idx = IW'(q.base + q.cx * sy * sz + q.cy * sz + q.cz
                       + $urandom_range(0, 2) - 1);
    else
      q.self_idx = IW'($urandom_range(0, (1 << IW) - 1));
    return q;
  endfunction

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- clip mode, straight out of reset ---
    offer_query(box_query(0, 0, 0, 1, 1, 1, 4, 4, 4, 0, 0));             // corner, self dropped
    offer_query(box_query(0, 0, 0, 0, 0, 0, 1, 1, 1, 'h5, 0));           // lone cell
    offer_query(box_query(0, 0, 0, 0, 0, 0, 1, 1, 1, 'h5, 'h5));         // lone cell is self
    offer_query(box_query(1, 1, 1, 1, 1, 1, 0, 4, 4, 0, 0));             // empty x axis
    offer_query(box_query(1, 1, 1, 1, 1, 1, 4, 4, 0, 0, 0));             // empty z axis
    offer_query(box_query(255, 255, 255, 1, 1, 1, 511, 300, 257, 'h12345, 'hFFFFF));
    offer_query(box_query(10, 200, 3, 1, 1, 1, 4, 4, 4, 0, 0));          // box off the grid
    offer_query(box_query(0, 0, 0, 3, 3, 3, 8, 8, 8, 'h100, 'hFFFFF));   // exactly 64
    offer_query(box_query(128, 128, 128, 3, 3, 3, 256, 256, 256, 'hFFFFF, 0)); // cut, wraps
    offer_query(box_query(5, 5, 5, 3, 0, 2, 16, 16, 16, 'hABCDE, 'hABCDE + 5*256 + 5*16 + 5));
    wait_drained();

    // --- torus mode ---
    set_wrap(WRAP_TORUS);
    offer_query(box_query(0, 0, 0, 1, 1, 1, 1, 1, 1, 'h7, 0));           // same cell 27 times
    offer_query(box_query(0, 0, 0, 1, 1, 1, 1, 1, 1, 'h7, 'h7));         // ... all of it self
    offer_query(box_query(255, 255, 255, 3, 3, 3, 2, 3, 5, 'hFFFF0, 0)); // box wider than grid
    offer_query(box_query(3, 3, 3, 1, 1, 1, 5, 0, 5, 0, 0));             // empty y axis
    offer_query(box_query(0, 0, 0, 2, 2, 2, 256, 256, 256, 0, 0));       // wraps below zero
    offer_query(box_query(255, 255, 255, 1, 1, 1, 511, 511, 511, 'hFFFFF, 'hFFFFF));
    offer_query(box_query(0, 128, 255, 0, 3, 1, 7, 200, 256, 'h80000, 'h7FFFF));
    wait_drained();

    // --- random phases, modes alternating; the last one runs without idling ---
    for (int phase = 0; phase < 4; phase++) begin
      set_wrap(phase % 2 ? WRAP_TORUS : WRAP_CLIP);
      calm = (phase == 3);
      for (int i = 0; i < 28; i++) begin
        if (phase == 1 && i == 5) hold_wanted = 1'b1;
        if (phase == 2 && i == 16) begin
          in_valid <= 1'b0;
          while (ledger.expected.size() != 0) @(posedge clk);
        end
        offer_query(random_query());
      end
      wait_drained();
    end

    $display("Covered %0d queries in clip and torus modes: %0d gave no neighbours, %0d were cut.",
             ledger.queries, ledger.empty_queries, ledger.cut_queries);
    $display("Checked %0d items; wrap_mode written %0d times, %0d long receiver hold-off(s).",
             ledger.results, wrap_writes, holds_done);
    if (ledger.failures == 0 && ledger.expected.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("%0t: timed out, %0d items still owed", $time, ledger.expected.size());
    $display("FAILURE");
    $finish;
  end

endmodule

[files.f]
rtl/core/bnig_pkg.sv
rtl/core/bnig_modunit.sv
rtl/core/bnig_emit.sv
rtl/core/box_neighbourhood_index_generator.sv
tb/tb.sv
